// ----- rtl/mrml_pkg.sv -----
// ----------------------------------------------------------------------------
// mrml_pkg
// Shared types, codes and the CRC-16 update for the Modbus RTU master link.
// ----------------------------------------------------------------------------
package mrml_pkg;

  // Input item kinds
  localparam logic [2:0] REQ_TX_BYTE   = 3'd0;
  localparam logic [2:0] REQ_RX_BYTE   = 3'd1;
  localparam logic [2:0] REQ_FRAME_END = 3'd2;
  localparam logic [2:0] REQ_TICK      = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Report status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_TIMEOUT   = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
  localparam logic [2:0] ST_BAD_CRC   = 3'd4;
  localparam logic [2:0] ST_EXCEPTION = 3'd5;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  FUNC_MASK    = 8'h7F;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;
  localparam int          MIN_FRAME    = 5;
  localparam logic [7:0]  PLEN_MAX     = 8'hFF;
  localparam logic [15:0] TIMEOUT_INIT = 16'd100;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] read_index;
  } mrml_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [7:0] station_address;
    logic [7:0] function_code;
    logic [7:0] payload_length;
    logic [7:0] read_byte;
    logic       last_out;
  } mrml_out_t;

  // Result group produced by one input item
  typedef enum logic [1:0] {
    BND_TX_ONE,
    BND_TX_CRC,
    BND_REPORT,
    BND_READ
  } mrml_bnd_type_t;

  typedef struct packed {
    mrml_bnd_type_t btype;
    logic [7:0]     tx_byte;
    logic [15:0]    crc;
    logic [2:0]     status;
    logic [7:0]     exc;
    logic [7:0]     addr;
    logic [7:0]     func;
    logic [7:0]     plen;
    logic           out_of_range;
  } mrml_bnd_t;

  // Fold one byte into a reflected CRC-16, one bit per step
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrml_ram.sv -----
// ----------------------------------------------------------------------------
// mrml_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mrml_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrml_ctrl
// Link state: transmit CRC and request tracking, receive CRC and byte count,
// timeout counter. Builds the result group of each accepted item and drives
// the receive buffer ports.
// ----------------------------------------------------------------------------
module mrml_ctrl
  import mrml_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  mrml_in_t                        in_data,
  input  logic                            cfg_we,
  input  logic [15:0]                     cfg_wdata,
  output logic                            bnd_load,
  output mrml_bnd_t                       bnd,
  output logic                            ram_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 2);
  localparam logic [CW-1:0] BUF_CNT = CW'(BUFFER_BYTES);
  localparam logic [CW-1:0] MIN_CNT = CW'(MIN_FRAME);
  localparam logic [CW-1:0] HDR_LEN = CW'(4);
  localparam logic [10:0]   BUF_IDX = 11'(BUFFER_BYTES);

  logic [15:0]   timeout_ms;
  logic [15:0]   tx_crc, tx_crc_next;
  logic [1:0]    tx_pos, tx_pos_next;
  logic          dropping, dropping_next;
  logic [7:0]    drop_addr, drop_addr_next;
  logic [7:0]    drop_func, drop_func_next;
  logic          pending, pending_next;
  logic [16:0]   elapsed, elapsed_next;
  logic [15:0]   rx_crc, rx_crc_next;
  logic [15:0]   rx_tail, rx_tail_next;
  logic [CW-1:0] rx_count, rx_count_next;
  logic [7:0]    hdr0, hdr1, hdr2;

  logic          accept;
  logic          drop_v;
  logic [7:0]    drop_addr_v, drop_func_v;
  logic [15:0]   tx_crc_v;
  logic [16:0]   elapsed_v;
  logic [15:0]   rx_got;
  logic [CW-1:0] plen_full;
  logic [10:0]   read_pos;

  assign accept    = in_valid && in_ready;
  assign rx_got    = {rx_tail[7:0], rx_tail[15:8]};
  assign plen_full = rx_count - HDR_LEN;
  assign read_pos  = 11'(in_data.read_index) + 11'd2;

  // Next state and result group of the accepted item
  always_comb begin
    tx_crc_next    = tx_crc;
    tx_pos_next    = tx_pos;
    dropping_next  = dropping;
    drop_addr_next = drop_addr;
    drop_func_next = drop_func;
    pending_next   = pending;
    elapsed_next   = elapsed;
    rx_crc_next    = rx_crc;
    rx_tail_next   = rx_tail;
    rx_count_next  = rx_count;
    bnd_load       = 1'b0;
    bnd            = '0;
    ram_we         = 1'b0;
    ram_waddr      = rx_count[AW-1:0];
    ram_wdata      = in_data.data_byte;
    ram_re         = 1'b0;
    ram_raddr      = read_pos[AW-1:0];
    drop_v         = dropping;
    drop_addr_v    = drop_addr;
    drop_func_v    = drop_func;
    tx_crc_v       = crc16_update(tx_crc, in_data.data_byte);
    elapsed_v      = (elapsed < ELAPSED_MAX) ? elapsed + 17'd1 : elapsed;
    if (accept) begin
      case (in_data.req_type)
        REQ_TX_BYTE: begin
          // Track request position; drop requests started while busy
          if (tx_pos == 2'd0) begin
            drop_v = pending;
            if (pending) begin
              drop_addr_v = in_data.data_byte;
              drop_func_v = 8'h00;
            end
          end else if (tx_pos == 2'd1 && dropping) begin
            drop_func_v = in_data.data_byte;
          end
          tx_pos_next    = (tx_pos == 2'd2) ? tx_pos : tx_pos + 2'd1;
          dropping_next  = drop_v;
          drop_addr_next = drop_addr_v;
          drop_func_next = drop_func_v;
          if (drop_v) begin
            if (in_data.last_byte) begin
              dropping_next = 1'b0;
              tx_pos_next   = 2'd0;
              bnd_load      = 1'b1;
              bnd.btype     = BND_REPORT;
              bnd.status    = ST_BUSY;
              bnd.addr      = drop_addr_v;
              bnd.func      = drop_func_v;
            end
          end else begin
            tx_crc_next = tx_crc_v;
            bnd_load    = 1'b1;
            bnd.tx_byte = in_data.data_byte;
            bnd.crc     = tx_crc_v;
            bnd.btype   = BND_TX_ONE;
            if (in_data.last_byte) begin
              bnd.btype    = BND_TX_CRC;
              tx_crc_next  = CRC_INIT;
              tx_pos_next  = 2'd0;
              pending_next = 1'b1;
              elapsed_next = '0;
            end
          end
        end
        REQ_RX_BYTE: begin
          // Shift in the byte; CRC lags two bytes behind
          if (rx_count >= CW'(2)) begin
            rx_crc_next = crc16_update(rx_crc, rx_tail[15:8]);
          end
          rx_tail_next = {rx_tail[7:0], in_data.data_byte};
          ram_we = rx_count < BUF_CNT;
          if (rx_count <= BUF_CNT) begin
            rx_count_next = rx_count + CW'(1);
          end
        end
        REQ_FRAME_END: begin
          pending_next  = 1'b0;
          elapsed_next  = '0;
          rx_crc_next   = CRC_INIT;
          rx_tail_next  = '0;
          rx_count_next = '0;
          bnd_load      = 1'b1;
          bnd.btype     = BND_REPORT;
          if (rx_count < MIN_CNT || rx_count > BUF_CNT) begin
            bnd.status = ST_BAD_SIZE;
          end else if (rx_got != rx_crc) begin
            bnd.status = ST_BAD_CRC;
          end else if (hdr1[7]) begin
            bnd.status = ST_EXCEPTION;
            bnd.exc    = hdr2;
            bnd.addr   = hdr0;
            bnd.func   = hdr1 & FUNC_MASK;
          end else begin
            bnd.status = ST_OK;
            bnd.addr   = hdr0;
            bnd.func   = hdr1 & FUNC_MASK;
            bnd.plen   = (plen_full > CW'(PLEN_MAX)) ? PLEN_MAX : plen_full[7:0];
          end
        end
        REQ_TICK: begin
          // Count while a request is outstanding; report once past the limit
          if (pending) begin
            elapsed_next = elapsed_v;
            if (elapsed_v > {1'b0, timeout_ms}) begin
              pending_next = 1'b0;
              elapsed_next = '0;
              bnd_load     = 1'b1;
              bnd.btype    = BND_REPORT;
              bnd.status   = ST_TIMEOUT;
            end
          end
        end
        REQ_READ: begin
          ram_re           = 1'b1;
          bnd_load         = 1'b1;
          bnd.btype        = BND_READ;
          bnd.out_of_range = read_pos >= BUF_IDX;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_INIT;
      tx_crc     <= CRC_INIT;
      tx_pos     <= '0;
      dropping   <= 1'b0;
      drop_addr  <= '0;
      drop_func  <= '0;
      pending    <= 1'b0;
      elapsed    <= '0;
      rx_crc     <= CRC_INIT;
      rx_tail    <= '0;
      rx_count   <= '0;
    end else begin
      if (cfg_we) begin
        timeout_ms <= cfg_wdata;
      end
      tx_crc    <= tx_crc_next;
      tx_pos    <= tx_pos_next;
      dropping  <= dropping_next;
      drop_addr <= drop_addr_next;
      drop_func <= drop_func_next;
      pending   <= pending_next;
      elapsed   <= elapsed_next;
      rx_crc    <= rx_crc_next;
      rx_tail   <= rx_tail_next;
      rx_count  <= rx_count_next;
    end
  end

  // Keep the frame header bytes beside the buffer for the frame-end check
  always_ff @(posedge clk) begin
    if (ram_we) begin
      if (rx_count == CW'(0)) begin
        hdr0 <= in_data.data_byte;
      end
      if (rx_count == CW'(1)) begin
        hdr1 <= in_data.data_byte;
      end
      if (rx_count == CW'(2)) begin
        hdr2 <= in_data.data_byte;
      end
    end
  end

endmodule

// ----- rtl/mrml_out.sv -----
// ----------------------------------------------------------------------------
// mrml_out
// Result side: one stage that waits for buffer read data, then an output
// stage that steps through the results of one group, one per transfer.
// ----------------------------------------------------------------------------
module mrml_out
  import mrml_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       bnd_load,
  input  mrml_bnd_t  bnd,
  input  logic [7:0] ram_rdata,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output mrml_out_t  out_data
);

  logic       s1_valid;
  mrml_bnd_t  s1_bnd;
  logic       o_valid;
  mrml_bnd_t  o_bnd;
  logic [7:0] o_read;
  logic [1:0] o_idx;
  logic       o_last;
  logic       o_free;
  logic       s1_adv;

  assign o_last   = (o_bnd.btype != BND_TX_CRC) || (o_idx == 2'd2);
  assign o_free   = !o_valid || (out_ready && o_last);
  assign s1_adv   = s1_valid && o_free;
  assign in_ready = !s1_valid || s1_adv;

  // Advance the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
      o_idx    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= bnd_load;
      end
      if (s1_adv) begin
        o_valid <= 1'b1;
        o_idx   <= '0;
      end else if (o_valid && out_ready) begin
        if (o_last) begin
          o_valid <= 1'b0;
        end else begin
          o_idx <= o_idx + 2'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && bnd_load) begin
      s1_bnd <= bnd;
    end
    if (s1_adv) begin
      o_bnd  <= s1_bnd;
      o_read <= s1_bnd.out_of_range ? 8'h00 : ram_rdata;
    end
  end

  // Form the current result
  always_comb begin
    out_valid         = o_valid;
    out_data          = '0;
    out_data.last_out = o_last;
    case (o_bnd.btype)
      BND_TX_ONE, BND_TX_CRC: begin
        out_data.out_kind = KIND_TX;
        case (o_idx)
          2'd0:    out_data.tx_byte = o_bnd.tx_byte;
          2'd1:    out_data.tx_byte = o_bnd.crc[7:0];
          default: out_data.tx_byte = o_bnd.crc[15:8];
        endcase
      end
      BND_REPORT: begin
        out_data.out_kind        = KIND_REPORT;
        out_data.status          = o_bnd.status;
        out_data.exception_code  = o_bnd.exc;
        out_data.station_address = o_bnd.addr;
        out_data.function_code   = o_bnd.func;
        out_data.payload_length  = o_bnd.plen;
      end
      default: begin
        out_data.out_kind  = KIND_READ;
        out_data.read_byte = o_read;
      end
    endcase
  end

endmodule

// ----- rtl/modbus_rtu_master_link_core.sv -----
// Path: each result passes the read-wait stage and then the output register
// before it is offered. Throughput: one item per cycle while the output is not
// stalled and each item gives at most one result; a request's last byte holds
// the output stage for three transfers (byte, CRC low, CRC high), set by the
// single output register stepping through them.
// Reset: synchronous, clears all link state, timeout returns to 100 ticks;
// the receive buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// modbus_rtu_master_link_core
// Modbus RTU master link: sends requests with CRC-16, checks received frames,
// times out requests and serves payload reads from the receive buffer.
// ----------------------------------------------------------------------------
module modbus_rtu_master_link_core
  import mrml_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mrml_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output mrml_out_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic          bnd_load;
  mrml_bnd_t     bnd;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  mrml_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .bnd_load (bnd_load),
    .bnd      (bnd),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr)
  );

  // Receive buffer
  mrml_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_rx_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mrml_out u_out (
    .clk      (clk),
    .rst      (rst),
    .bnd_load (bnd_load),
    .bnd      (bnd),
    .ram_rdata(ram_rdata),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- test/mrml_link_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrml_link_checker
// Watches the item, result and register ports of the Modbus RTU master link.
// It predicts every result from its own copy of the link state and compares
// each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mrml_link_checker
  import mrml_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  mrml_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  mrml_out_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          awaiting
);

  localparam int AW = $clog2(BUFFER_BYTES);

  // Predicted link state
  logic [15:0] tmo;
  logic [15:0] send_crc;
  logic [1:0]  send_pos;
  logic        drop_req;
  logic [7:0]  drop_addr;
  logic [7:0]  drop_func;
  logic        req_open;
  logic [16:0] ticks;
  logic [15:0] recv_crc;
  logic [15:0] recv_tail;
  logic [10:0] recv_count;
  logic [7:0]  recv_buf [BUFFER_BYTES];

  logic [15:0] crc_lut [256];
  mrml_out_t   due_results [$];

  // Build the byte-wide lookup for the reflected CRC-16
  initial begin
    logic [15:0] v;
    for (int i = 0; i < 256; i++) begin
      v = i[15:0];
      for (int k = 0; k < 8; k++) begin
        v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      crc_lut[i[7:0]] = v;
    end
  end

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_lut[crc[7:0] ^ b];
  endfunction

  // Append one predicted result behind the others
  function automatic void add_due(input mrml_out_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic mrml_out_t tx_result(input logic [7:0] b, input logic fin);
    mrml_out_t r;
    r = '0;
    r.out_kind = KIND_TX;
    r.tx_byte  = b;
    r.last_out = fin;
    return r;
  endfunction

  function automatic mrml_out_t status_report(input logic [2:0] st, input logic [7:0] exc,
                                              input logic [7:0] addr, input logic [7:0] fn,
                                              input logic [7:0] plen);
    mrml_out_t r;
    r = '0;
    r.out_kind        = KIND_REPORT;
    r.status          = st;
    r.exception_code  = exc;
    r.station_address = addr;
    r.function_code   = fn;
    r.payload_length  = plen;
    r.last_out        = 1'b1;
    return r;
  endfunction

  // Work out the results one accepted item causes and queue them
  task automatic link_response(input mrml_in_t it);
    int          n;
    int          idx;
    logic [15:0] got;
    logic [15:0] calc;
    logic [7:0]  plen;
    mrml_out_t   r;
    case (it.req_type)
      REQ_TX_BYTE: begin
        // first byte decides whether the request goes out or is dropped
        if (send_pos == 2'd0) begin
          drop_req = req_open;
          if (drop_req) begin
            drop_addr = it.data_byte;
            drop_func = 8'h00;
          end
        end else if (send_pos == 2'd1 && drop_req) begin
          drop_func = it.data_byte;
        end
        if (send_pos < 2'd2) send_pos = send_pos + 2'd1;
        if (drop_req) begin
          if (it.last_byte) begin
            drop_req = 1'b0;
            send_pos = 2'd0;
            add_due(status_report(ST_BUSY, 8'h00, drop_addr, drop_func, 8'h00));
          end
        end else begin
          send_crc = crc_step(send_crc, it.data_byte);
          add_due(tx_result(it.data_byte, !it.last_byte));
          if (it.last_byte) begin
            // append CRC low byte first, then open the request
            add_due(tx_result(send_crc[7:0], 1'b0));
            add_due(tx_result(send_crc[15:8], 1'b1));
            send_crc = CRC_INIT;
            send_pos = 2'd0;
            req_open = 1'b1;
            ticks    = '0;
          end
        end
      end
      REQ_RX_BYTE: begin
        // CRC trails the two newest bytes
        if (recv_count >= 2) recv_crc = crc_step(recv_crc, recv_tail[15:8]);
        recv_tail = {recv_tail[7:0], it.data_byte};
        if (recv_count < BUFFER_BYTES) recv_buf[recv_count[AW-1:0]] = it.data_byte;
        if (recv_count <= BUFFER_BYTES) recv_count = recv_count + 11'd1;
      end
      REQ_FRAME_END: begin
        n    = int'(recv_count);
        calc = recv_crc;
        got  = {recv_tail[7:0], recv_tail[15:8]};
        req_open   = 1'b0;
        ticks      = '0;
        recv_crc   = CRC_INIT;
        recv_tail  = '0;
        recv_count = '0;
        if (n < MIN_FRAME || n > BUFFER_BYTES) begin
          add_due(status_report(ST_BAD_SIZE, 8'h00, 8'h00, 8'h00, 8'h00));
        end else if (got != calc) begin
          add_due(status_report(ST_BAD_CRC, 8'h00, 8'h00, 8'h00, 8'h00));
        end else if (recv_buf[1][7]) begin
          add_due(status_report(ST_EXCEPTION, recv_buf[2], recv_buf[0],
                                recv_buf[1] & FUNC_MASK, 8'h00));
        end else begin
          if (n - 4 > 255) plen = PLEN_MAX;
          else plen = 8'(n - 4);
          add_due(status_report(ST_OK, 8'h00, recv_buf[0],
                                recv_buf[1] & FUNC_MASK, plen));
        end
      end
      REQ_TICK: begin
        // count only while a request is open, saturating
        if (req_open) begin
          if (ticks < ELAPSED_MAX) ticks = ticks + 17'd1;
          if (ticks > {1'b0, tmo}) begin
            req_open = 1'b0;
            ticks    = '0;
            add_due(status_report(ST_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'h00));
          end
        end
      end
      REQ_READ: begin
        idx = int'(it.read_index) + 2;
        r = '0;
        r.out_kind  = KIND_READ;
        r.read_byte = (idx < BUFFER_BYTES) ? recv_buf[idx[AW-1:0]] : 8'h00;
        r.last_out  = 1'b1;
        add_due(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Track transfers on all three ports
  always @(posedge clk) begin
    mrml_out_t want;
    if (rst) begin
      tmo        = TIMEOUT_INIT;
      send_crc   = CRC_INIT;
      send_pos   = 2'd0;
      drop_req   = 1'b0;
      drop_addr  = 8'h00;
      drop_func  = 8'h00;
      req_open   = 1'b0;
      ticks      = '0;
      recv_crc   = CRC_INIT;
      recv_tail  = '0;
      recv_count = '0;
      due_results.delete();
    end else begin
      // compare first, so a result that nothing predicted is never masked
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing predicted, kind %0d", out_data.out_kind);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("out_kind", 8'(want.out_kind), 8'(out_data.out_kind));
          check_field("tx_byte", want.tx_byte, out_data.tx_byte);
          check_field("status", 8'(want.status), 8'(out_data.status));
          check_field("exception_code", want.exception_code, out_data.exception_code);
          check_field("station_address", want.station_address, out_data.station_address);
          check_field("function_code", want.function_code, out_data.function_code);
          check_field("payload_length", want.payload_length, out_data.payload_length);
          check_field("read_byte", want.read_byte, out_data.read_byte);
          check_field("last_out", 8'(want.last_out), 8'(out_data.last_out));
        end
      end
      if (in_valid && in_ready) link_response(in_data);
      if (cfg_we) tmo = cfg_wdata;
    end
    awaiting = due_results.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the Modbus RTU master link with directed and random traffic: request
// bytes, received frames (good, corrupt and short), ticks and payload reads,
// over several timeout settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import mrml_pkg::*;

  localparam int BUFFER_BYTES  = 256;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_INDEX     = 251;
  localparam int EXCHANGES     = 3;
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  mrml_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mrml_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int          mismatches;
  int          awaiting;

  // Sender pacing and receive buffer bookkeeping
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  int frame_len  = 0;
  int fill       = 0;

  // Receiver stall pattern
  int         stall_mode = 0;
  int         stall_age  = 0;
  logic [7:0] stall_pat  = 8'b1011_0010;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  modbus_rtu_master_link_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  mrml_link_checker #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  // Stall the result side, switching the pattern now and then
  always @(posedge clk) begin
    if (stall_age == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_age  = $urandom_range(20, 80);
    end
    stall_age--;
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_pat[0];
    endcase
  end

  // Hold one item until it is transferred; gaps fall between bursts
  task automatic send_item(input logic [2:0] kind, input logic [7:0] data, input logic fin,
                           input logic [7:0] idx);
    mrml_in_t it;
    logic     took;
    it.req_type   = kind;
    it.data_byte  = data;
    it.last_byte  = fin;
    it.read_index = idx;
    if (kind == REQ_RX_BYTE) begin
      if (frame_len <= BUFFER_BYTES) frame_len++;
      if (frame_len > fill && frame_len <= BUFFER_BYTES) fill = frame_len;
    end else if (kind == REQ_FRAME_END) begin
      frame_len = 0;
    end
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Random payload index whose buffer entry has been written
  function automatic int safe_index();
    return $urandom_range(0, (fill - 3 > MAX_INDEX) ? MAX_INDEX : fill - 3);
  endfunction

  task automatic send_request(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(REQ_TX_BYTE, 8'($urandom_range(0, 255)), i == len - 1,
                8'($urandom_range(0, MAX_INDEX)));
    end
  endtask

  // Frame of len bytes including CRC, then frame end
  task automatic send_frame(input int len, input bit good, input bit exc);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    for (int i = 0; i < len - 2; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 1) b[7] = exc;
      crc = crc16_update(crc, b);
      send_item(REQ_RX_BYTE, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, MAX_INDEX)));
    end
    if (!good) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_item(REQ_RX_BYTE, crc[7:0], 1'($urandom_range(0, 1)),
              8'($urandom_range(0, MAX_INDEX)));
    send_item(REQ_RX_BYTE, crc[15:8], 1'($urandom_range(0, 1)),
              8'($urandom_range(0, MAX_INDEX)));
    send_item(REQ_FRAME_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, MAX_INDEX)));
  endtask

  // Raw bytes, then frame end
  task automatic send_junk(input int n);
    repeat (n) send_item(REQ_RX_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, MAX_INDEX)));
    send_item(REQ_FRAME_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, MAX_INDEX)));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, MAX_INDEX)));
  endtask

  task automatic read_payload(input int idx);
    send_item(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 8'(idx));
  endtask

  // Any item kind with random fields
  task automatic send_noise();
    logic [2:0] kind;
    kind = 3'($urandom_range(0, 7));
    if (kind == REQ_READ && fill < 3) kind = REQ_UNUSED_LO;
    send_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              8'((kind == REQ_READ) ? safe_index() : $urandom_range(0, MAX_INDEX)));
  endtask

  // Drop valid, wait for every predicted result, then let the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] timeout_plan(input int ph);
    case (ph)
      1:       return 16'd0;
      2:       return 16'hFFFF;
      3:       return 16'd3;
      4:       return 16'($urandom_range(1, 8));
      default: return 16'd2;
    endcase
  endfunction

  task automatic run_directed();
    // one-byte request goes out with its CRC
    send_item(REQ_TX_BYTE, 8'hFF, 1'b1, 8'd0);
    // busy while outstanding: one-byte, then three-byte request
    send_item(REQ_TX_BYTE, 8'h00, 1'b1, 8'd251);
    send_item(REQ_TX_BYTE, 8'h11, 1'b0, 8'd0);
    send_item(REQ_TX_BYTE, 8'h83, 1'b0, 8'd0);
    send_item(REQ_TX_BYTE, 8'h00, 1'b1, 8'd0);
    send_ticks(1);
    // short frame clears the open request
    send_junk(3);
    send_ticks(1);
    send_junk(0);
    // smallest good frame, a read, an exception and a corrupt CRC
    send_frame(5, 1'b1, 1'b0);
    read_payload(0);
    send_frame(5, 1'b1, 1'b1);
    send_frame(6, 1'b0, 1'b0);
    send_item(REQ_UNUSED_LO, 8'hA5, 1'b1, 8'd0);
    send_item(REQ_UNUSED_HI, 8'h5A, 1'b0, 8'd251);
    send_request(2);
  endtask

  task automatic random_exchange();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_request($urandom_range(1, 6));
    end else if (pick < 58) begin
      send_frame($urandom_range(5, 12), $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
    end else if (pick < 66) begin
      send_junk($urandom_range(0, 4));
    end else if (pick < 78) begin
      send_ticks($urandom_range(1, 8));
    end else if (pick < 92) begin
      if (fill >= 3) read_payload(safe_index());
    end else begin
      send_noise();
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle();
        write_timeout(timeout_plan(ph));
      end
      gaps_on = (ph != 3);
      if (ph == 0) run_directed();
      repeat (EXCHANGES) random_exchange();
    end
    settle();
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
